// File: sv/mie_pkg.sv
// Shared types and constants of the MIPS32 instruction executor.
// Holds the transaction structs, status and memory codes, and opcode tables.
// No dependencies.
`default_nettype none

package mie_pkg;

  localparam logic [31:0] START_ADDR_RESET = 32'h0000_1000;
  localparam logic [31:0] JUMP_REGION_MASK = 32'hf000_0000;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_LOAD       = 3'd1,
    ST_ILLEGAL    = 3'd2,
    ST_SYSCALL    = 3'd3,
    ST_UNEXPECTED = 3'd4,
    ST_HALTED     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_e;

  typedef enum logic [1:0] {
    MW_BYTE = 2'd0,
    MW_HALF = 2'd1,
    MW_WORD = 2'd2
  } mem_width_e;

  typedef enum logic [2:0] {
    LK_LB  = 3'd0,
    LK_LH  = 3'd1,
    LK_LW  = 3'd2,
    LK_LBU = 3'd3,
    LK_LHU = 3'd4
  } load_kind_e;

  localparam logic [0:0] MODE_EXEC = 1'b0;
  localparam logic [0:0] MODE_DATA = 1'b1;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // function codes under OP_SPECIAL
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  // syscall codes that let execution continue
  localparam logic [31:0] SC_PRINT_INT    = 32'd1;
  localparam logic [31:0] SC_PRINT_STRING = 32'd4;
  localparam logic [31:0] SC_PRINT_CHAR   = 32'd11;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_V0   = 5'd2;
  localparam logic [4:0] REG_A0   = 5'd4;
  localparam logic [4:0] REG_RA   = 5'd31;

  typedef struct packed {
    logic        mode;
    logic [31:0] instr;
    logic [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [1:0]  mem_width;
    logic [31:0] store_data;
    logic [31:0] syscall_code;
    logic [31:0] syscall_arg;
  } out_item_t;

  // architectural state besides the register file
  typedef struct packed {
    logic [31:0] pc;
    logic        load_waiting;
    logic [4:0]  load_dest;
    load_kind_e  load_kind;
    logic        halted;
  } arch_t;

  // register file write port
  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } wb_t;

endpackage

`default_nettype wire

// File: sv/mie_regfile.sv
// General register file: 32 x 32 memory with per-entry valid bits and write bypass.
// Registered rs/rt read ports plus shadow copies of v0 and a0. Uses mie_pkg.
`default_nettype none

module mie_regfile (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [4:0]    rs_addr_i,
  input  wire logic [4:0]    rt_addr_i,
  input  wire mie_pkg::wb_t  wb_i,
  output logic [31:0]        rs_data_o,
  output logic [31:0]        rt_data_o,
  output logic [31:0]        v0_o,
  output logic [31:0]        a0_o
);
  import mie_pkg::*;

  logic [31:0] mem_q [32];
  logic [31:0] valid_q;
  logic [31:0] rs_data_q;
  logic [31:0] rt_data_q;
  logic [31:0] v0_q;
  logic [31:0] a0_q;
  logic        wr_en;

  assign wr_en = wb_i.en && (wb_i.addr != REG_ZERO);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wb_i.addr] <= wb_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      v0_q    <= '0;
      a0_q    <= '0;
    end else if (wr_en) begin
      valid_q[wb_i.addr] <= 1'b1;
      if (wb_i.addr == REG_V0) begin
        v0_q <= wb_i.data;
      end
      if (wb_i.addr == REG_A0) begin
        a0_q <= wb_i.data;
      end
    end
  end

  // never-written entries and register zero read as zero
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (rs_addr_i == REG_ZERO) begin
        rs_data_q <= '0;
      end else if (wr_en && (wb_i.addr == rs_addr_i)) begin
        rs_data_q <= wb_i.data;
      end else begin
        rs_data_q <= valid_q[rs_addr_i] ? mem_q[rs_addr_i] : '0;
      end
      if (rt_addr_i == REG_ZERO) begin
        rt_data_q <= '0;
      end else if (wr_en && (wb_i.addr == rt_addr_i)) begin
        rt_data_q <= wb_i.data;
      end else begin
        rt_data_q <= valid_q[rt_addr_i] ? mem_q[rt_addr_i] : '0;
      end
    end
  end

  assign rs_data_o = rs_data_q;
  assign rt_data_o = rt_data_q;
  assign v0_o      = v0_q;
  assign a0_o      = a0_q;

endmodule

`default_nettype wire

// File: sv/mie_exec.sv
// Execute logic: decodes one transaction and forms the result, the register
// write and the next architectural state. Purely combinational. Uses mie_pkg.
`default_nettype none

module mie_exec (
  input  wire mie_pkg::in_item_t  item_i,
  input  wire mie_pkg::arch_t     arch_i,
  input  wire logic [31:0]        rs_val_i,
  input  wire logic [31:0]        rt_val_i,
  input  wire logic [31:0]        v0_i,
  input  wire logic [31:0]        a0_i,
  output mie_pkg::out_item_t      res_o,
  output mie_pkg::arch_t          arch_o,
  output mie_pkg::wb_t            wb_o
);
  import mie_pkg::*;

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] br_target;
  logic [31:0] j_target;
  logic [31:0] ea;
  logic [31:0] ld_ext;
  logic [31:0] ld;

  assign op   = item_i.instr[31:26];
  assign rt   = item_i.instr[20:16];
  assign rd   = item_i.instr[15:11];
  assign sh   = item_i.instr[10:6];
  assign fn   = item_i.instr[5:0];
  assign imm  = {16'h0000, item_i.instr[15:0]};
  assign simm = {{16{item_i.instr[15]}}, item_i.instr[15:0]};
  assign pc4  = arch_i.pc + 32'd4;
  assign br_target = pc4 + {simm[29:0], 2'b00};
  assign j_target  = (pc4 & JUMP_REGION_MASK) | {4'h0, item_i.instr[25:0], 2'b00};
  assign ea   = rs_val_i + simm;
  assign ld   = item_i.load_data;

  always_comb begin
    case (arch_i.load_kind)
      LK_LB:   ld_ext = {{24{ld[7]}}, ld[7:0]};
      LK_LH:   ld_ext = {{16{ld[15]}}, ld[15:0]};
      LK_LBU:  ld_ext = {24'h000000, ld[7:0]};
      LK_LHU:  ld_ext = {16'h0000, ld[15:0]};
      default: ld_ext = ld;
    endcase
  end

  always_comb begin
    res_o         = '0;
    res_o.status  = ST_OK;
    res_o.next_pc = pc4;
    arch_o        = arch_i;
    wb_o          = '0;
    wb_o.addr     = rd;

    if (arch_i.halted) begin
      res_o.status  = ST_HALTED;
      res_o.next_pc = arch_i.pc;
    end else if (item_i.mode == MODE_DATA) begin
      res_o.next_pc = arch_i.pc;
      if (!arch_i.load_waiting) begin
        res_o.status = ST_UNEXPECTED;
      end else begin
        wb_o.en             = 1'b1;
        wb_o.addr           = arch_i.load_dest;
        wb_o.data           = ld_ext;
        arch_o.load_waiting = 1'b0;
      end
    end else if (arch_i.load_waiting) begin
      res_o.status  = ST_LOAD;
      res_o.next_pc = arch_i.pc;
    end else if (op == OP_SPECIAL) begin
      case (fn)
        FN_SLL: begin
          wb_o.en   = 1'b1;
          wb_o.data = rt_val_i << sh;
        end
        FN_SRL: begin
          wb_o.en   = 1'b1;
          wb_o.data = rt_val_i >> sh;
        end
        FN_SRA: begin
          wb_o.en   = 1'b1;
          wb_o.data = $unsigned($signed(rt_val_i) >>> sh);
        end
        FN_JR: begin
          res_o.next_pc = rs_val_i;
        end
        FN_JALR: begin
          // target uses rs as read before the link write
          res_o.next_pc = rs_val_i;
          wb_o.en       = 1'b1;
          wb_o.data     = pc4;
        end
        FN_SYSCALL: begin
          res_o.status       = ST_SYSCALL;
          res_o.syscall_code = v0_i;
          res_o.syscall_arg  = a0_i;
          if (!(v0_i inside {SC_PRINT_INT, SC_PRINT_STRING, SC_PRINT_CHAR})) begin
            arch_o.halted = 1'b1;
            res_o.next_pc = arch_i.pc;
          end
        end
        FN_ADDU: begin
          wb_o.en   = 1'b1;
          wb_o.data = rs_val_i + rt_val_i;
        end
        FN_SUBU: begin
          wb_o.en   = 1'b1;
          wb_o.data = rs_val_i - rt_val_i;
        end
        FN_AND: begin
          wb_o.en   = 1'b1;
          wb_o.data = rs_val_i & rt_val_i;
        end
        FN_OR: begin
          wb_o.en   = 1'b1;
          wb_o.data = rs_val_i | rt_val_i;
        end
        FN_XOR: begin
          wb_o.en   = 1'b1;
          wb_o.data = rs_val_i ^ rt_val_i;
        end
        FN_NOR: begin
          wb_o.en   = 1'b1;
          wb_o.data = ~(rs_val_i | rt_val_i);
        end
        FN_SLT: begin
          wb_o.en   = 1'b1;
          wb_o.data = {31'd0, $signed(rs_val_i) < $signed(rt_val_i)};
        end
        FN_SLTU: begin
          wb_o.en   = 1'b1;
          wb_o.data = {31'd0, rs_val_i < rt_val_i};
        end
        default: begin
          res_o.status  = ST_ILLEGAL;
          arch_o.halted = 1'b1;
          res_o.next_pc = arch_i.pc;
        end
      endcase
    end else begin
      wb_o.addr = rt;
      case (op)
        OP_J: begin
          res_o.next_pc = j_target;
        end
        OP_JAL: begin
          res_o.next_pc = j_target;
          wb_o.en       = 1'b1;
          wb_o.addr     = REG_RA;
          wb_o.data     = pc4;
        end
        OP_BEQ: begin
          if (rs_val_i == rt_val_i) begin
            res_o.next_pc = br_target;
          end
        end
        OP_BNE: begin
          if (rs_val_i != rt_val_i) begin
            res_o.next_pc = br_target;
          end
        end
        OP_ADDIU: begin
          wb_o.en   = 1'b1;
          wb_o.data = ea;
        end
        OP_SLTI: begin
          wb_o.en   = 1'b1;
          wb_o.data = {31'd0, $signed(rs_val_i) < $signed(simm)};
        end
        OP_SLTIU: begin
          // immediate is sign extended, then compared unsigned
          wb_o.en   = 1'b1;
          wb_o.data = {31'd0, rs_val_i < simm};
        end
        OP_ANDI: begin
          wb_o.en   = 1'b1;
          wb_o.data = rs_val_i & imm;
        end
        OP_ORI: begin
          wb_o.en   = 1'b1;
          wb_o.data = rs_val_i | imm;
        end
        OP_XORI: begin
          wb_o.en   = 1'b1;
          wb_o.data = rs_val_i ^ imm;
        end
        OP_LUI: begin
          wb_o.en   = 1'b1;
          wb_o.data = {item_i.instr[15:0], 16'h0000};
        end
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
          res_o.status        = ST_LOAD;
          res_o.mem_op        = MEM_READ;
          res_o.mem_addr      = ea;
          arch_o.load_waiting = 1'b1;
          arch_o.load_dest    = rt;
          case (op)
            OP_LB: begin
              arch_o.load_kind = LK_LB;
              res_o.mem_width  = MW_BYTE;
            end
            OP_LH: begin
              arch_o.load_kind = LK_LH;
              res_o.mem_width  = MW_HALF;
            end
            OP_LBU: begin
              arch_o.load_kind = LK_LBU;
              res_o.mem_width  = MW_BYTE;
            end
            OP_LHU: begin
              arch_o.load_kind = LK_LHU;
              res_o.mem_width  = MW_HALF;
            end
            default: begin
              arch_o.load_kind = LK_LW;
              res_o.mem_width  = MW_WORD;
            end
          endcase
        end
        OP_SB, OP_SH, OP_SW: begin
          res_o.mem_op     = MEM_WRITE;
          res_o.mem_addr   = ea;
          res_o.store_data = rt_val_i;
          case (op)
            OP_SB:   res_o.mem_width = MW_BYTE;
            OP_SH:   res_o.mem_width = MW_HALF;
            default: res_o.mem_width = MW_WORD;
          endcase
        end
        default: begin
          res_o.status  = ST_ILLEGAL;
          arch_o.halted = 1'b1;
          res_o.next_pc = arch_i.pc;
        end
      endcase
    end

    arch_o.pc = res_o.next_pc;
  end

endmodule

`default_nettype wire

// File: sv/mips_instruction_executor_top.sv
// MIPS32 integer instruction executor, top level.
// Input register, register file, execute logic and result register. Uses mie_pkg.
//
// Usage: each input transaction carries either an instruction word fetched at
// the current program counter (mode 0) or the right-aligned read data of a
// pending load (mode 1). Every input transaction yields exactly one result
// transaction with status, next fetch address, an optional memory request and
// syscall code/argument. A load issue reports status 1 and a read request;
// the next transaction must then bring the data in mode 1.
// The config channel writes the start address and reloads the program counter;
// write it only while no transaction is in flight.
// The register file is read alongside the input register when a transaction is
// accepted, the result register loads when it leaves the input register, and
// the result is then held until taken. Throughput: one transaction per cycle
// while the receiver takes results; the register file read for the next
// transaction bypasses the write of the one ahead.
// Reset: program counter 0x1000, all registers zero, no load pending.
// When the receiver stalls, the result register holds, the input register
// fills behind it and in_ready_o falls until the result is taken.
`default_nettype none

module mips_instruction_executor_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire mie_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mie_pkg::out_item_t       out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [31:0]         cfg_data_i
);
  import mie_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  arch_t     arch_q;
  arch_t     arch_d;
  arch_t     arch_exec;
  out_item_t res;
  wb_t       wb_exec;
  wb_t       wb;
  logic      advance;
  logic      accept;
  logic      cfg_wr;
  logic [31:0] rs_val;
  logic [31:0] rt_val;
  logic [31:0] v0_val;
  logic [31:0] a0_val;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  // state only moves when a transaction leaves the input register or a config write reloads the program counter
  always_comb begin
    wb          = wb_exec;
    wb.en       = wb_exec.en && advance;
    arch_d      = arch_q;
    if (advance) begin
      arch_d = arch_exec;
    end
    if (cfg_wr) begin
      arch_d.pc = cfg_data_i;
    end
  end

  mie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rs_addr_i (in_item_i.instr[25:21]),
    .rt_addr_i (in_item_i.instr[20:16]),
    .wb_i      (wb),
    .rs_data_o (rs_val),
    .rt_data_o (rt_val),
    .v0_o      (v0_val),
    .a0_o      (a0_val)
  );

  mie_exec u_exec (
    .item_i   (s1_item_q),
    .arch_i   (arch_q),
    .rs_val_i (rs_val),
    .rt_val_i (rt_val),
    .v0_i     (v0_val),
    .a0_i     (a0_val),
    .res_o    (res),
    .arch_o   (arch_exec),
    .wb_o     (wb_exec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q.pc           <= START_ADDR_RESET;
      arch_q.load_waiting <= 1'b0;
      arch_q.load_dest    <= REG_ZERO;
      arch_q.load_kind    <= LK_LB;
      arch_q.halted       <= 1'b0;
      s1_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      arch_q <= arch_d;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
